>>> rtl/eftl_pkg.sv
// Shared constants for the eased frame-time lookup unit.
// Holds command, curve and status codes and the field widths.
// No dependencies.
package eftl_pkg;

	localparam int MAX_FRAMES_DEF = 64;

	localparam int MODE_W   = 3;
	localparam int SLOT_W   = 6;
	localparam int DUR_W    = 16;
	localparam int TIME_W   = 19;
	localparam int IDX_W    = 6;
	localparam int TOTAL_W  = 22;
	localparam int STATUS_W = 2;
	localparam int CURVE_W  = 3;

	localparam int IN_W  = 48;
	localparam int OUT_W = 48;

	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SETALL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

	localparam logic [CURVE_W-1:0] CURVE_EASE_IN  = 3'd1;
	localparam logic [CURVE_W-1:0] CURVE_EASE_OUT = 3'd2;
	localparam logic [CURVE_W-1:0] CURVE_SMOOTH   = 3'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	localparam logic [DUR_W-1:0]   MIN_SET_MS = 16'd10;
	localparam logic [16:0]        Q16_ONE    = 17'h10000;
	localparam logic [17:0]        Q16_THREE  = 18'd196608;
	localparam logic [TOTAL_W-1:0] SUM_MAX    = 22'h3FFFFF;

endpackage

>>> rtl/eftl_mul.sv
// Shared registered multiplier of the eased frame-time lookup unit.
// The product register loads only when enabled, so it holds a result.
// No dependencies.
module eftl_mul #(
	parameter int A_W = 18,
	parameter int B_W = 23
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic [A_W+B_W-1:0]   p
);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

endmodule

>>> rtl/eftl_ram.sv
// Duration table storage: one write port and one read port with registered
// read data. No dependencies.
module eftl_ram #(
	parameter int DEPTH = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/eased_frame_time_lookup_unit.sv
// Top level of the eased frame-time lookup unit: command sequencer, table and
// shared multiplier. Depends on eftl_pkg, eftl_mul and eftl_ram.
//
// One request is taken at a time. Append, clear and unused commands go straight
// to the output step; read and set at index first read the table entry, set-all
// rewrites every entry, and a query passes the curve and the scaling by the
// total through one registered multiplier in up to three passes, and the
// prefix search then reads the table one entry per cycle through its single
// read port, stopping at the first frame that reaches the target. A result
// waits in the output register without holding up the next request; the next
// result is loaded once the previous one has been taken. The total is kept
// exact internally and saturates only on the output.
module eased_frame_time_lookup_unit #(
	parameter int MAX_FRAMES = eftl_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [eftl_pkg::CURVE_W-1:0]  cfg_wdata,   // curve_mode
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mode[2:0], frame_slot[8:3], new_duration[24:9], norm_time[43:25]
	input  logic [eftl_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_index[5:0], duration_out[21:6], total_duration[43:22], status[45:44]
	output logic [eftl_pkg::OUT_W-1:0]    m_tdata
);

	import eftl_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int AW    = $clog2(MAX_FRAMES);
	localparam int SW    = DUR_W + CNT_W;
	localparam int CW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
	localparam int SWX   = (SW > TOTAL_W) ? SW : TOTAL_W;
	localparam int MA    = 18;
	localparam int MB    = (SW > 18) ? SW : 18;
	localparam int PW    = MA + MB;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_OUT    = 4'd1;
	localparam logic [3:0] S_SETW   = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_SWEEP  = 4'd4;
	localparam logic [3:0] S_SUM    = 4'd5;
	localparam logic [3:0] S_SQ     = 4'd6;
	localparam logic [3:0] S_CRV    = 4'd7;
	localparam logic [3:0] S_SMOOTH = 4'd8;
	localparam logic [3:0] S_TGT    = 4'd9;
	localparam logic [3:0] S_SCAN   = 4'd10;

	logic [3:0]          state_q;
	logic [CURVE_W-1:0]  curve_q;
	logic [CNT_W-1:0]    count_q;
	logic [SW-1:0]       sum_q;
	logic [AW-1:0]       slot_q;
	logic [DUR_W-1:0]    dur_q;
	logic [16:0]         t_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    idx_q;
	logic [SW-1:0]       acc_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [DUR_W-1:0]    res_dur_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                m_tvalid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [DUR_W-1:0]    out_dur_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [MODE_W-1:0]   in_mode;
	logic [SLOT_W-1:0]   in_slot;
	logic [DUR_W-1:0]    in_dur;
	logic [TIME_W-1:0]   in_time;
	logic                accept;
	logic                out_load;
	logic [CW-1:0]       slot_cw;
	logic [CW-1:0]       count_cw;
	logic                slot_bad;
	logic [CNT_W-1:0]    last_idx;
	logic [16:0]         t_clamp;
	logic [16:0]         p_hi;
	logic [16:0]         curve_c;
	logic [17:0]         smooth_f;
	logic [SW-1:0]       acc_n;
	logic [PW-1:0]       cmp_rhs;
	logic                hit;
	logic [CW-1:0]       idx_cw;
	logic [SWX-1:0]      sum_x;
	logic [TOTAL_W-1:0]  total_sat;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DUR_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [DUR_W-1:0]    ram_rdata;
	logic                mul_en;
	logic [MA-1:0]       mul_a;
	logic [MB-1:0]       mul_b;
	logic [PW-1:0]       mul_p;

	eftl_ram #(
		.DEPTH  (MAX_FRAMES),
		.ADDR_W (AW),
		.DATA_W (DUR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	eftl_mul #(
		.A_W (MA),
		.B_W (MB)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign in_mode = s_tdata[2:0];
	assign in_slot = s_tdata[8:3];
	assign in_dur  = s_tdata[24:9];
	assign in_time = s_tdata[43:25];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	assign slot_cw  = CW'(in_slot);
	assign count_cw = CW'(count_q);
	assign slot_bad = (slot_cw >= count_cw);
	assign last_idx = count_q - CNT_W'(1);

	always_comb begin
		if (in_time[TIME_W-1]) begin
			t_clamp = '0;
		end else if (in_time[17:0] > 18'(Q16_ONE)) begin
			t_clamp = Q16_ONE;
		end else begin
			t_clamp = in_time[16:0];
		end
	end

	assign p_hi     = mul_p[32:16];
	assign smooth_f = Q16_THREE - {t_q, 1'b0};

	always_comb begin
		case (curve_q)
			CURVE_EASE_IN:  curve_c = p_hi;
			CURVE_EASE_OUT: curve_c = Q16_ONE - p_hi;
			default:        curve_c = t_q;
		endcase
	end

	// The target stays in the product register for the whole scan.
	assign acc_n   = acc_q + SW'(ram_rdata);
	assign cmp_rhs = {{(PW - SW - 16){1'b0}}, acc_n, 16'h0000};
	assign hit     = (mul_p <= cmp_rhs);
	assign idx_cw  = CW'(idx_q);

	assign sum_x     = SWX'(sum_q);
	assign total_sat = (sum_x > SWX'(SUM_MAX)) ? SUM_MAX : sum_x[TOTAL_W-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = dur_q;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_mode == MODE_APPEND && count_q < CNT_W'(MAX_FRAMES)) begin
						ram_we    = 1'b1;
						ram_waddr = count_q[AW-1:0];
						ram_wdata = in_dur;
					end
					if ((in_mode == MODE_SET || in_mode == MODE_READ) && !slot_bad) begin
						ram_re    = 1'b1;
						ram_raddr = slot_cw[AW-1:0];
					end
				end
			end
			S_SETW: begin
				ram_we = 1'b1;
			end
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[AW-1:0];
				if (ptr_q == '0) begin
					mul_en = 1'b1;
					mul_a  = MA'(dur_q);
					mul_b  = MB'(count_q);
				end
			end
			S_SQ: begin
				mul_en = 1'b1;
				if (curve_q == CURVE_EASE_OUT) begin
					mul_a = MA'(Q16_ONE - t_q);
					mul_b = MB'(Q16_ONE - t_q);
				end else begin
					mul_a = MA'(t_q);
					mul_b = MB'(t_q);
				end
			end
			S_CRV: begin
				mul_en = 1'b1;
				if (curve_q == CURVE_SMOOTH) begin
					mul_a = smooth_f;
					mul_b = MB'(p_hi);
				end else begin
					mul_a = MA'(curve_c);
					mul_b = MB'(sum_q);
				end
			end
			S_SMOOTH: begin
				mul_en = 1'b1;
				mul_a  = MA'(p_hi);
				mul_b  = MB'(sum_q);
			end
			S_TGT: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_SCAN: begin
				ram_re = (ptr_q < count_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			curve_q      <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			m_tvalid_q   <= 1'b0;
			slot_q       <= '0;
			dur_q        <= '0;
			t_q          <= '0;
			ptr_q        <= '0;
			idx_q        <= '0;
			acc_q        <= '0;
			res_idx_q    <= '0;
			res_dur_q    <= '0;
			res_status_q <= ST_OK;
			out_idx_q    <= '0;
			out_dur_q    <= '0;
			out_total_q  <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				curve_q <= cfg_wdata;
			end
			// A new result may replace the one taken in the same cycle.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_idx_q    <= '0;
						res_dur_q    <= '0;
						res_status_q <= ST_OK;
						slot_q       <= slot_cw[AW-1:0];
						dur_q        <= in_dur;
						t_q          <= t_clamp;
						ptr_q        <= '0;
						state_q      <= S_OUT;
						case (in_mode)
							MODE_APPEND: begin
								if (count_q >= CNT_W'(MAX_FRAMES)) begin
									res_status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
									sum_q   <= sum_q + SW'(in_dur);
								end
							end
							MODE_SET: begin
								if (slot_bad) begin
									res_status_q <= ST_RANGE;
								end else begin
									state_q <= S_SETW;
								end
							end
							MODE_CLEAR: begin
								count_q <= '0;
								sum_q   <= '0;
							end
							MODE_SETALL: begin
								dur_q <= (in_dur < MIN_SET_MS) ? MIN_SET_MS : in_dur;
								if (count_q != '0) begin
									state_q <= S_SWEEP;
								end
							end
							MODE_QUERY: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else if (curve_q == CURVE_EASE_IN ||
										curve_q == CURVE_EASE_OUT ||
										curve_q == CURVE_SMOOTH) begin
									state_q <= S_SQ;
								end else begin
									state_q <= S_CRV;
								end
							end
							MODE_READ: begin
								if (slot_bad) begin
									res_status_q <= ST_RANGE;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SETW: begin
					sum_q   <= sum_q - SW'(ram_rdata) + SW'(dur_q);
					state_q <= S_OUT;
				end
				S_RD: begin
					res_dur_q <= ram_rdata;
					state_q   <= S_OUT;
				end
				S_SWEEP: begin
					if (ptr_q == last_idx) begin
						state_q <= S_SUM;
					end else begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				S_SUM: begin
					sum_q   <= mul_p[SW-1:0];
					state_q <= S_OUT;
				end
				S_SQ: begin
					state_q <= S_CRV;
				end
				S_CRV: begin
					state_q <= (curve_q == CURVE_SMOOTH) ? S_SMOOTH : S_TGT;
				end
				S_SMOOTH: begin
					state_q <= S_TGT;
				end
				S_TGT: begin
					ptr_q   <= CNT_W'(1);
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (hit || idx_q == last_idx) begin
						res_idx_q <= idx_cw[IDX_W-1:0];
						state_q   <= S_OUT;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
						acc_q <= acc_n;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_idx_q    <= res_idx_q;
						out_dur_q    <= res_dur_q;
						out_total_q  <= total_sat;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_status_q, out_total_q, out_dur_q, out_idx_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAMES))
		else $error("frame count exceeds table depth");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("nonzero total with an empty table");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_mode == MODE_APPEND && count_q < CNT_W'(MAX_FRAMES))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance the frame count");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q < count_q))
		else $error("scan index past the last frame");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside the output step");

endmodule

>>> bench/eased_frame_time_lookup_unit_tb.sv
// Self-checking bench for the eased frame-time lookup unit: drives command
// requests over the input stream, predicts every result and checks the output.
// Depends on eftl_pkg and eased_frame_time_lookup_unit.
`timescale 1ns / 1ps

module eased_frame_time_lookup_unit_tb;
	import eftl_pkg::*;

	localparam logic [MODE_W-1:0] MODE_NOP_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_NOP_B = 3'd7;

	localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd0;
	localparam logic [CURVE_W-1:0] CURVE_CUSTOM = 3'd4;
	localparam logic [CURVE_W-1:0] CURVE_RSVD_5 = 3'd5;
	localparam logic [CURVE_W-1:0] CURVE_RSVD_6 = 3'd6;
	localparam logic [CURVE_W-1:0] CURVE_RSVD_7 = 3'd7;

	localparam int PHASE_ITEMS = 185;
	localparam int PRINT_LIMIT = 30;
	localparam int TAB_AW      = $clog2(MAX_FRAMES_DEF);

	typedef struct packed {
		logic [TIME_W-1:0] ntime;
		logic [DUR_W-1:0]  dur;
		logic [SLOT_W-1:0] slot;
		logic [MODE_W-1:0] mode;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TOTAL_W-1:0]  total;
		logic [DUR_W-1:0]    dur_out;
		logic [IDX_W-1:0]    frame_index;
	} result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CURVE_W-1:0] cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;

	eased_frame_time_lookup_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Request and result stores.
	cmd_t    cmd_queue[$];
	result_t pending_results[$];

	// Shadow of the block's state.
	logic [DUR_W-1:0]   frame_tab [0:MAX_FRAMES_DEF-1];
	int                 frame_cnt = 0;
	logic [CURVE_W-1:0] curve_sel = CURVE_LINEAR;

	int gen_count = 0;
	int n_pushed = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_queries = 0;
	int n_reads = 0;
	int status_hits[4] = '{0, 0, 0, 0};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		n_errors++;
		if (n_errors <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", n_checked, what);
	endtask

	function automatic longint unsigned table_total();
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < frame_cnt; i++)
			acc += 64'(frame_tab[TAB_AW'(i)]);
		return acc;
	endfunction

	// Applies one command to the shadow state and returns the result it produces.
	function automatic result_t run_command(input cmd_t c);
		result_t         r;
		longint unsigned t, cv, u, s, target, acc, sum;
		logic [DUR_W-1:0] d;
		int              last;
		bit              hit;
		r = '0;
		r.status = ST_OK;
		case (c.mode)
			MODE_APPEND: begin
				if (frame_cnt >= MAX_FRAMES_DEF) begin
					r.status = ST_FULL;
				end else begin
					frame_tab[TAB_AW'(frame_cnt)] = c.dur;
					frame_cnt++;
				end
			end
			MODE_SET: begin
				if (c.slot >= frame_cnt)
					r.status = ST_RANGE;
				else
					frame_tab[c.slot] = c.dur;
			end
			MODE_CLEAR: begin
				frame_cnt = 0;
			end
			MODE_SETALL: begin
				d = (c.dur < MIN_SET_MS) ? MIN_SET_MS : c.dur;
				for (int i = 0; i < frame_cnt; i++)
					frame_tab[TAB_AW'(i)] = d;
			end
			MODE_QUERY: begin
				n_queries++;
				if (frame_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (c.ntime[TIME_W-1])
						t = 0;
					else if (c.ntime > Q16_ONE)
						t = 64'(Q16_ONE);
					else
						t = 64'(c.ntime);
					case (curve_sel)
						CURVE_EASE_IN: cv = (t * t) >> 16;
						CURVE_EASE_OUT: begin
							u = Q16_ONE - t;
							cv = Q16_ONE - ((u * u) >> 16);
						end
						CURVE_SMOOTH: begin
							s = (t * t) >> 16;
							cv = (s * (Q16_THREE - 2 * t)) >> 16;
						end
						default: cv = t;
					endcase
					target = cv * table_total();
					last = frame_cnt - 1;
					r.frame_index = last[IDX_W-1:0];
					acc = 0;
					hit = 1'b0;
					for (int i = 0; i < frame_cnt && !hit; i++) begin
						acc += 64'(frame_tab[TAB_AW'(i)]);
						if (target <= (acc << 16)) begin
							r.frame_index = i[IDX_W-1:0];
							hit = 1'b1;
						end
					end
				end
			end
			MODE_READ: begin
				n_reads++;
				if (c.slot >= frame_cnt)
					r.status = ST_RANGE;
				else
					r.dur_out = frame_tab[c.slot];
			end
			default: ;
		endcase
		sum = table_total();
		r.total = (sum > SUM_MAX) ? SUM_MAX : sum[TOTAL_W-1:0];
		status_hits[r.status]++;
		return r;
	endfunction

	// Driver: sends queued requests in bursts separated by random gaps.
	cmd_t on_bus;
	int   burst_left = 1;
	int   gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.insert(pending_results.size(), run_command(on_bus));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					on_bus = cmd_queue.pop_front();
					s_tdata <= {{(IN_W - $bits(cmd_t)){1'b0}}, on_bus};
					s_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						// Now and then a long stretch with no gaps at all.
						if ($urandom_range(0, 3) == 0) begin
							burst_left = $urandom_range(80, 200);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 20);
							gap_left = $urandom_range(0, 20);
						end
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: drives the result-side stall pattern and checks every result.
	int         hold_left = 0;
	int         seg_left = 0;
	int         seg_style = 0;
	bit         hold_req = 1'b0;
	logic [7:0] stall_pat = 8'b1011_0010;
	logic       rdy;
	result_t    got;
	result_t    want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (pending_results.size() == 0) begin
					flag_mismatch("result arrived with no request outstanding");
				end else begin
					want = pending_results.pop_front();
					if (got.frame_index !== want.frame_index)
						flag_mismatch($sformatf("frame_index got %0d want %0d",
							got.frame_index, want.frame_index));
					if (got.dur_out !== want.dur_out)
						flag_mismatch($sformatf("duration_out got %0d want %0d",
							got.dur_out, want.dur_out));
					if (got.total !== want.total)
						flag_mismatch($sformatf("total_duration got %0d want %0d",
							got.total, want.total));
					if (got.status !== want.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							got.status, want.status));
				end
				n_checked++;
			end

			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = $urandom_range(300, 600);
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_style = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 200);
				end else begin
					seg_left--;
				end
				case (seg_style)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 1) == 1);
					2: rdy = ($urandom_range(0, 3) == 0);
					default: begin
						rdy = stall_pat[0];
						stall_pat = {stall_pat[0], stall_pat[7:1]};
					end
				endcase
			end
			m_tready <= rdy;
		end
	end

	// Stimulus.
	task automatic push_cmd(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] sl,
			input logic [DUR_W-1:0] d, input logic [TIME_W-1:0] nt);
		cmd_t c;
		c.mode = m;
		c.slot = sl;
		c.dur = d;
		c.ntime = nt;
		cmd_queue.insert(cmd_queue.size(), c);
		n_pushed++;
		if (m == MODE_APPEND && gen_count < MAX_FRAMES_DEF)
			gen_count++;
		else if (m == MODE_CLEAR)
			gen_count = 0;
	endtask

	function automatic logic [DUR_W-1:0] rand_dur();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return DUR_W'($urandom_range(0, 12));
			3, 4, 5: return DUR_W'($urandom_range(1, 200));
			default: return DUR_W'($urandom);
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		int v;
		case ($urandom_range(0, 11))
			0: v = 0;
			1: v = 65536;
			2: v = -131072;
			3: v = 131072;
			4: v = $urandom_range(65537, 131072);
			5: begin
				v = $urandom_range(1, 131072);
				v = -v;
			end
			6: begin
				v = $urandom_range(0, 262144);
				v = v - 131072;
			end
			default: v = $urandom_range(0, 65536);
		endcase
		return v[TIME_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] rand_slot();
		if (gen_count > 0 && $urandom_range(0, 4) != 0)
			return SLOT_W'($urandom_range(0, gen_count - 1));
		return SLOT_W'($urandom_range(0, MAX_FRAMES_DEF - 1));
	endfunction

	task automatic mixed_cmd();
		int pick;
		logic [MODE_W-1:0] m;
		pick = $urandom_range(0, 99);
		if (pick < 18)
			m = MODE_APPEND;
		else if (pick < 28)
			m = MODE_SET;
		else if (pick < 31)
			m = MODE_CLEAR;
		else if (pick < 36)
			m = MODE_SETALL;
		else if (pick < 76)
			m = MODE_QUERY;
		else if (pick < 98)
			m = MODE_READ;
		else
			m = $urandom_range(0, 1) ? MODE_NOP_A : MODE_NOP_B;
		push_cmd(m, rand_slot(), rand_dur(), rand_time());
	endtask

	// Clears the table, refills it and then works on the fresh contents.
	task automatic fill_episode(input int n, input int style);
		logic [DUR_W-1:0] d;
		push_cmd(MODE_CLEAR, SLOT_W'($urandom), DUR_W'($urandom), TIME_W'($urandom));
		for (int i = 0; i < n; i++) begin
			case (style)
				0: d = rand_dur();
				1: d = '1;
				default: d = DUR_W'($urandom_range(0, 20));
			endcase
			push_cmd(MODE_APPEND, SLOT_W'($urandom), d, TIME_W'($urandom));
		end
		repeat ($urandom_range(10, 30))
			mixed_cmd();
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
	endtask

	task automatic write_curve(input logic [CURVE_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		curve_sel = v;
	endtask

	logic [CURVE_W-1:0] phase_curves[8] = '{CURVE_RSVD_7, CURVE_EASE_IN, CURVE_EASE_OUT,
		CURVE_SMOOTH, CURVE_CUSTOM, CURVE_RSVD_5, CURVE_RSVD_6, CURVE_LINEAR};
	int phase_start;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset curve.
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_READ, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_SET, 6'd63, 16'd1, 19'd0);
		push_cmd(MODE_SETALL, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_APPEND, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_APPEND, 6'd0, 16'hFFFF, 19'd0);
		push_cmd(MODE_APPEND, 6'd0, 16'd3, 19'd0);
		push_cmd(MODE_READ, 6'd2, 16'd0, 19'd0);
		push_cmd(MODE_SETALL, 6'd0, 16'd3, 19'd0);
		push_cmd(MODE_READ, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_SET, 6'd1, 16'hFFFF, 19'd0);
		push_cmd(MODE_SET, 6'd3, 16'd7, 19'd0);
		push_cmd(MODE_READ, 6'd63, 16'd0, 19'd0);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h7FFFF);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h60000);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h20000);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h10000);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h10001);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h08000);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'd1);
		push_cmd(MODE_NOP_A, 6'd63, 16'hFFFF, 19'h7FFFF);
		push_cmd(MODE_NOP_B, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_CLEAR, 6'd0, 16'd0, 19'd0);
		push_cmd(MODE_QUERY, 6'd0, 16'd0, 19'h08000);
		push_cmd(MODE_APPEND, 6'd0, 16'hFFFF, 19'd0);

		for (int p = 0; p < 8; p++) begin
			// The curve register may only change while nothing is in flight.
			wait_drained();
			repeat (10) @(posedge clk);
			write_curve(phase_curves[p]);
			phase_start = n_pushed;
			if (p == 0)
				fill_episode(66, 1);
			else
				fill_episode($urandom_range(1, 68), $urandom_range(0, 2));
			while (n_pushed - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0)
					fill_episode($urandom_range(1, 68), $urandom_range(0, 2));
				else
					repeat ($urandom_range(10, 40))
						mixed_cmd();
			end
			if (p == 1 || p == 5)
				hold_req = 1'b1;
		end

		wait_drained();
		repeat (80) @(posedge clk);
		$display("Sent %0d requests under 8 curve settings, %0d queries, %0d reads, %0d checked.",
			n_pushed, n_queries, n_reads, n_checked);
		$display("Status ok/range/full/empty seen %0d/%0d/%0d/%0d times.",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/eftl_pkg.sv
rtl/eftl_mul.sv
rtl/eftl_ram.sv
rtl/eased_frame_time_lookup_unit.sv
bench/eased_frame_time_lookup_unit_tb.sv
